FILE: rtl/core/dgt_pkg.sv
package dgt_pkg;

    localparam int IDX_W     = 20;
    localparam int ELEV_W    = 32;
    localparam int SIZE_W    = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NODATA_VALUE = 2'd2;

    localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = 11'd1024;
    localparam logic [ELEV_W-1:0] NODATA_RESET    = 32'hFFFF_D8F1;

    localparam int QUEUE_DEPTH = 2;

    typedef logic [IDX_W-1:0] vidx_t;

    // one completed cell: which halves to emit and the four corner indices
    typedef struct packed {
        logic  upper;
        logic  lower;
        vidx_t ul;
        vidx_t ur;
        vidx_t ll;
        vidx_t lr;
    } cell_word_t;

endpackage

FILE: rtl/core/dgt_cfg_if.sv
interface dgt_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [dgt_pkg::CFG_IDX_W-1:0]       index;
    logic [dgt_pkg::ELEV_W-1:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/dgt_in_if.sv
interface dgt_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [dgt_pkg::ELEV_W-1:0]   elevation;

    modport source (output valid, elevation, input ready);
    modport sink   (input valid, elevation, output ready);
endinterface

FILE: rtl/core/dgt_out_if.sv
interface dgt_out_if;
    logic                 valid;
    logic                 ready;
    dgt_pkg::vidx_t       vertex_a;
    dgt_pkg::vidx_t       vertex_b;
    dgt_pkg::vidx_t       vertex_c;
    logic                 triangle_half;
    logic                 last;

    modport source (output valid, vertex_a, vertex_b, vertex_c, triangle_half, last,
                    input ready);
    modport sink   (input valid, vertex_a, vertex_b, vertex_c, triangle_half, last,
                    output ready);
endinterface

FILE: rtl/core/dgt_front.sv
module dgt_front #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    dgt_cfg_if.sink             cfg,
    dgt_in_if.sink              sample,
    output dgt_pkg::cell_word_t word,
    output logic                word_valid,
    input  logic                word_ready
);

    localparam int CW  = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RW  = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
    localparam int CSW = $clog2(MAX_COLUMNS + 1);
    localparam int RSW = $clog2(MAX_ROWS + 1);

    logic [dgt_pkg::SIZE_W-1:0] columns_reg;
    logic [dgt_pkg::SIZE_W-1:0] rows_reg;
    logic [dgt_pkg::ELEV_W-1:0] nodata_reg;

    logic [CSW-1:0]        cols;
    logic [RSW-1:0]        rows;
    logic [CW-1:0]         col_reg;
    logic [RW-1:0]         row_reg;
    dgt_pkg::vidx_t        point_reg;
    logic                  ll_reg;
    logic                  ul_reg;

    logic                  line_mem [MAX_COLUMNS];

    logic                  s1_valid_reg;
    logic                  s1_up_reg;
    logic                  s1_cur_reg;
    logic                  s1_ll_reg;
    logic                  s1_inner_reg;
    dgt_pkg::vidx_t        s1_point_reg;
    logic [CSW-1:0]        s1_cols_reg;

    logic                  accept;
    logic                  cur;
    logic                  col_end;
    logic                  row_end;
    logic                  upper;
    logic                  lower;
    logic                  s1_take;
    dgt_pkg::vidx_t        cols_ext;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= dgt_pkg::GRID_SIZE_RESET;
            rows_reg    <= dgt_pkg::GRID_SIZE_RESET;
            nodata_reg  <= dgt_pkg::NODATA_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                dgt_pkg::REG_GRID_COLUMNS: columns_reg <= cfg.data[dgt_pkg::SIZE_W-1:0];
                dgt_pkg::REG_GRID_ROWS:    rows_reg    <= cfg.data[dgt_pkg::SIZE_W-1:0];
                dgt_pkg::REG_NODATA_VALUE: nodata_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    // sizes saturated to [2, MAX]
    always_comb
    begin
        if (columns_reg < 11'd2)
            cols = CSW'(2);
        else if (32'(columns_reg) > 32'(MAX_COLUMNS))
            cols = CSW'(MAX_COLUMNS);
        else
            cols = CSW'(columns_reg);

        if (rows_reg < 11'd2)
            rows = RSW'(2);
        else if (32'(rows_reg) > 32'(MAX_ROWS))
            rows = RSW'(MAX_ROWS);
        else
            rows = RSW'(rows_reg);
    end

    assign accept  = sample.valid && sample.ready;
    assign cur     = sample.elevation != $signed(nodata_reg);
    assign col_end = (32'(col_reg) + 32'd1) >= 32'(cols);
    assign row_end = (32'(row_reg) + 32'd1) >= 32'(rows);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            point_reg <= '0;
            ll_reg    <= 1'b0;
        end
        else if (accept)
        begin
            ll_reg <= cur;
            if (col_end)
            begin
                col_reg <= '0;
                if (row_end)
                begin
                    row_reg   <= '0;
                    point_reg <= '0;
                end
                else
                begin
                    row_reg   <= row_reg + 1'b1;
                    point_reg <= point_reg + 1'b1;
                end
            end
            else
            begin
                col_reg   <= col_reg + 1'b1;
                point_reg <= point_reg + 1'b1;
            end
        end
    end

    // line store: old mark read out, new mark written, same cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_up_reg         <= line_mem[col_reg];
            line_mem[col_reg] <= cur;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cur_reg   <= cur;
            s1_ll_reg    <= ll_reg;
            s1_inner_reg <= (row_reg != '0) && (col_reg != '0);
            s1_point_reg <= point_reg;
            s1_cols_reg  <= cols;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            ul_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_take)
                s1_valid_reg <= 1'b0;
            if (s1_take)
                ul_reg <= s1_up_reg;
        end
    end

    assign upper = s1_inner_reg && ul_reg && s1_up_reg && s1_ll_reg;
    assign lower = s1_inner_reg && s1_ll_reg && s1_up_reg && s1_cur_reg;

    assign cols_ext   = dgt_pkg::IDX_W'(s1_cols_reg);
    assign word.upper = upper;
    assign word.lower = lower;
    assign word.ur    = s1_point_reg - cols_ext;
    assign word.ul    = s1_point_reg - cols_ext - 1'b1;
    assign word.ll    = s1_point_reg - 1'b1;
    assign word.lr    = s1_point_reg;

    assign word_valid   = s1_valid_reg && (upper || lower);
    assign s1_take      = s1_valid_reg && (!(upper || lower) || word_ready);
    assign sample.ready = !s1_valid_reg || s1_take;

endmodule

FILE: rtl/core/dgt_queue.sv
module dgt_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  dgt_pkg::cell_word_t push_word,
    input  logic                push_valid,
    output logic                push_ready,
    output dgt_pkg::cell_word_t pop_word,
    output logic                pop_valid,
    input  logic                pop_ready
);

    localparam int PW = (dgt_pkg::QUEUE_DEPTH > 2) ? $clog2(dgt_pkg::QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(dgt_pkg::QUEUE_DEPTH + 1);

    dgt_pkg::cell_word_t entry_reg [dgt_pkg::QUEUE_DEPTH];
    logic [PW-1:0]       wr_ptr_reg;
    logic [PW-1:0]       rd_ptr_reg;
    logic [NW-1:0]       count_reg;
    logic                push;
    logic                pop;

    assign push_ready = count_reg != NW'(dgt_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_word   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(dgt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(dgt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: rtl/core/dgt_back.sv
module dgt_back (
    input  logic                clk,
    input  logic                rst_n,
    input  dgt_pkg::cell_word_t word,
    input  logic                word_valid,
    output logic                word_ready,
    dgt_out_if.source           triangle
);

    logic           out_valid_reg;
    dgt_pkg::vidx_t va_reg;
    dgt_pkg::vidx_t vb_reg;
    dgt_pkg::vidx_t vc_reg;
    logic           half_reg;
    logic           last_reg;
    logic           done0_reg;
    logic           load;
    logic           emit_upper;

    assign load       = !out_valid_reg || triangle.ready;
    assign emit_upper = word.upper && !done0_reg;
    assign word_ready = load && !(emit_upper && word.lower);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            done0_reg     <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= word_valid;
            if (word_valid)
                done0_reg <= emit_upper && word.lower;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && word_valid)
        begin
            if (emit_upper)
            begin
                va_reg   <= word.ul;
                vb_reg   <= word.ur;
                vc_reg   <= word.ll;
                half_reg <= 1'b0;
                last_reg <= !word.lower;
            end
            else
            begin
                va_reg   <= word.ll;
                vb_reg   <= word.ur;
                vc_reg   <= word.lr;
                half_reg <= 1'b1;
                last_reg <= 1'b1;
            end
        end
    end

    assign triangle.valid         = out_valid_reg;
    assign triangle.vertex_a      = va_reg;
    assign triangle.vertex_b      = vb_reg;
    assign triangle.vertex_c      = vc_reg;
    assign triangle.triangle_half = half_reg;
    assign triangle.last          = last_reg;

    // upper-left triangle: UR sits one column right of UL
    a_upper_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !half_reg |-> vb_reg == va_reg + 1'b1)
        else $error("upper triangle corners inconsistent");

    // lower-right triangle closes the word and LR follows LL
    a_lower_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && half_reg |-> last_reg && vc_reg == va_reg + 1'b1)
        else $error("lower triangle corners inconsistent");

    // a pending second half means a non-last upper triangle is on display
    a_pending_half: assert property (@(posedge clk) disable iff (!rst_n)
        done0_reg |-> out_valid_reg && !half_reg && !last_reg)
        else $error("second half pending without upper triangle shown");

endmodule

FILE: rtl/core/dem_grid_triangulator_unit.sv
// Grid triangulator: streams raster elevation samples in row-major order and
// returns, for each sample that completes a grid cell, the cell's triangles
// whose three corners are not no-data, as linear vertex indices.
// Channels: cfg (index, data) writes grid_columns (0), grid_rows (1) and
// the no-data code (2); always ready. The user must write cfg only while the
// block is idle; the block itself does not enforce this. sample carries one
// elevation word; triangle carries vertex_a/b/c, triangle_half (0 upper-left,
// 1 lower-right) and last, set on the final triangle of a sample. Half 0
// precedes half 1. A triangle passes the classifier register, the queue
// and the output register. Throughput: one sample per cycle while triangle
// does not stall; a sample with two triangles holds the single output
// register for each in turn, so the one-word output channel sets the pace.
// A two-entry queue separates the classifier from the emitter, so sample
// keeps being taken while triangle stalls, until the queue fills.
// Reset clears counters, corner marks and all valid flags; the line store of
// previous-row marks is not cleared and is written before it is read.
module dem_grid_triangulator_unit #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    dgt_cfg_if.sink    cfg,
    dgt_in_if.sink     sample,
    dgt_out_if.source  triangle
);

    dgt_pkg::cell_word_t push_word;
    logic                push_valid;
    logic                push_ready;
    dgt_pkg::cell_word_t pop_word;
    logic                pop_valid;
    logic                pop_ready;

    dgt_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .sample     (sample),
        .word       (push_word),
        .word_valid (push_valid),
        .word_ready (push_ready)
    );

    dgt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_word  (push_word),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_word   (pop_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    dgt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .word       (pop_word),
        .word_valid (pop_valid),
        .word_ready (pop_ready),
        .triangle   (triangle)
    );

endmodule

FILE: dv/dem_grid_triangulator_unit_test.sv
`timescale 1ns / 1ps

module dem_grid_triangulator_unit_test;

    localparam int MAX_COLUMNS      = 1024;
    localparam int MAX_ROWS         = 1024;
    localparam logic [dgt_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES    = 6;
    localparam int HOLD_CYCLES      = 80;
    localparam int DRAIN_CYCLES     = 20;
    localparam int RANDOM_SAMPLES   = 480;
    localparam int WIDE_ROW_SAMPLES = 300;

    typedef struct packed {
        dgt_pkg::vidx_t a;
        dgt_pkg::vidx_t b;
        dgt_pkg::vidx_t c;
        logic           half;
        logic           last;
    } tri_t;

    typedef enum logic {STEP_CFG, STEP_SAMPLE} step_kind_t;

    typedef struct {
        step_kind_t                    kind;
        logic [dgt_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [dgt_pkg::ELEV_W-1:0]    word;
        int                            known;
        tri_t                          t0;
        tri_t                          t1;
    } plan_row_t;

    logic clk;
    logic rst_n;

    dgt_cfg_if cfg_bus();
    dgt_in_if  sample_bus();
    dgt_out_if tri_bus();

    dem_grid_triangulator_unit #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .sample  (sample_bus),
        .triangle(tri_bus)
    );

    // grid state mirror
    logic [dgt_pkg::SIZE_W-1:0] grid_cols_reg;
    logic [dgt_pkg::SIZE_W-1:0] grid_rows_reg;
    logic [dgt_pkg::ELEV_W-1:0] nodata_reg;
    bit                         line_marks [MAX_COLUMNS];
    bit                         ul_mark = 1'b0;
    bit                         ll_mark = 1'b0;
    int                         col_cnt = 0;
    int                         row_cnt = 0;
    dgt_pkg::vidx_t             pt_idx = '0;
    int                         line_fill = 0;

    tri_t      pending_tris [$];
    plan_row_t plan [$];

    int errors       = 0;
    int samples_sent = 0;
    int tris_checked = 0;
    int lower_halves = 0;
    int cfg_writes   = 0;
    int grids_done   = 0;
    int holds_done   = 0;
    int burst_left   = 0;
    bit hold_pending = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1500000;
        $display("dem_grid_triangulator_unit regression: fail");
        $finish;
    end

    function automatic tri_t mk_tri(input int a, input int b, input int c,
                                    input bit h, input bit l);
        tri_t t;
        t.a    = dgt_pkg::vidx_t'(a);
        t.b    = dgt_pkg::vidx_t'(b);
        t.c    = dgt_pkg::vidx_t'(c);
        t.half = h;
        t.last = l;
        return t;
    endfunction

    function automatic int eff_size(input logic [dgt_pkg::SIZE_W-1:0] raw, input int hi);
        if (raw < 2)
            return 2;
        if (raw > hi)
            return hi;
        return int'(raw);
    endfunction

    task automatic add_step(input step_kind_t kind,
                            input logic [dgt_pkg::CFG_IDX_W-1:0] idx,
                            input logic [dgt_pkg::ELEV_W-1:0] word, input int known,
                            input tri_t t0, input tri_t t1);
        plan_row_t step_row;
        step_row.kind    = kind;
        step_row.reg_idx = idx;
        step_row.word    = word;
        step_row.known   = known;
        step_row.t0      = t0;
        step_row.t1      = t1;
        plan.insert(plan.size(), step_row);
    endtask

    task automatic triangulate_sample(input logic [dgt_pkg::ELEV_W-1:0] elev, output int n,
                                      output tri_t t0, output tri_t t1);
        int             cols;
        int             rows;
        bit             cur;
        bit             up;
        dgt_pkg::vidx_t p;
        tri_t           found [2];
        cols     = eff_size(grid_cols_reg, MAX_COLUMNS);
        rows     = eff_size(grid_rows_reg, MAX_ROWS);
        p        = pt_idx;
        cur      = (elev != nodata_reg);
        up       = line_marks[col_cnt];
        found[0] = '0;
        found[1] = '0;
        n        = 0;
        line_marks[col_cnt] = cur;
        if (col_cnt + 1 > line_fill)
            line_fill = col_cnt + 1;
        if (row_cnt >= 1 && col_cnt >= 1)
        begin
            if (ul_mark && up && ll_mark)
            begin
                found[n] = mk_tri(int'(p) - cols - 1, int'(p) - cols, int'(p) - 1, 1'b0, 1'b0);
                n++;
            end
            if (ll_mark && up && cur)
            begin
                found[n] = mk_tri(int'(p) - 1, int'(p) - cols, int'(p), 1'b1, 1'b0);
                n++;
            end
            if (n > 0)
                found[n-1].last = 1'b1;
        end
        ul_mark = up;
        ll_mark = cur;
        if (col_cnt + 1 >= cols)
        begin
            col_cnt = 0;
            if (row_cnt + 1 >= rows)
            begin
                row_cnt = 0;
                pt_idx  = '0;
                grids_done++;
            end
            else
            begin
                row_cnt++;
                pt_idx = p + 1'b1;
            end
        end
        else
        begin
            col_cnt++;
            pt_idx = p + 1'b1;
        end
        t0 = found[0];
        t1 = found[1];
    endtask

    task automatic write_reg(input logic [dgt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dgt_pkg::ELEV_W-1:0] word);
        sample_bus.valid <= 1'b0;
        while (pending_tris.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= word;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            dgt_pkg::REG_GRID_COLUMNS: grid_cols_reg = word[dgt_pkg::SIZE_W-1:0];
            dgt_pkg::REG_GRID_ROWS:    grid_rows_reg = word[dgt_pkg::SIZE_W-1:0];
            dgt_pkg::REG_NODATA_VALUE: nodata_reg    = word;
            default: ;
        endcase
        cfg_writes++;
    endtask

    // known >= 0 overrides the mirror with hand-written triangles
    task automatic send_sample(input logic [dgt_pkg::ELEV_W-1:0] elev, input int known,
                               input tri_t k0, input tri_t k1);
        int   n;
        tri_t t0;
        tri_t t1;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) == 0)
            begin
                sample_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        burst_left--;
        sample_bus.valid     <= 1'b1;
        sample_bus.elevation <= elev;
        do @(posedge clk); while (!sample_bus.ready);
        triangulate_sample(elev, n, t0, t1);
        if (known >= 0)
        begin
            n  = known;
            t0 = k0;
            t1 = k1;
        end
        if (n > 0)
            pending_tris.insert(pending_tris.size(), t0);
        if (n > 1)
            pending_tris.insert(pending_tris.size(), t1);
        samples_sent++;
    endtask

    function automatic logic [dgt_pkg::ELEV_W-1:0] pick_elevation(input int blank_pct);
        int                         sel;
        logic [dgt_pkg::ELEV_W-1:0] e;
        sel = $urandom_range(0, 99);
        e   = $urandom();
        if (sel < blank_pct)
            e = nodata_reg;
        else if (sel < blank_pct + 5)
            e = nodata_reg ^ (32'd1 << $urandom_range(0, 31));
        else if (sel < blank_pct + 10)
        begin
            case ($urandom_range(0, 3))
                0:       e = 32'h8000_0000;
                1:       e = 32'h7FFF_FFFF;
                2:       e = '0;
                default: e = '1;
            endcase
        end
        return e;
    endfunction

    // limit: largest usable column count without reading unwritten line marks
    function automatic logic [dgt_pkg::SIZE_W-1:0] pick_size(input int limit,
                                                             input int common_hi);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return dgt_pkg::SIZE_W'($urandom_range(0, 1));
        if (sel == 1)
            return (limit >= MAX_COLUMNS) ? dgt_pkg::SIZE_W'($urandom_range(1024, 2047))
                                          : dgt_pkg::SIZE_W'(limit);
        return dgt_pkg::SIZE_W'($urandom_range(2, (limit < common_hi) ? limit : common_hi));
    endfunction

    function automatic logic [dgt_pkg::ELEV_W-1:0] size_word(
        input logic [dgt_pkg::SIZE_W-1:0] raw);
        logic [dgt_pkg::ELEV_W-1:0] w;
        w = $urandom_range(0, 1) ? $urandom() : '0;
        w[dgt_pkg::SIZE_W-1:0] = raw;
        return w;
    endfunction

    always @(posedge clk)
    begin
        tri_t got;
        tri_t want;
        if (rst_n && tri_bus.valid && tri_bus.ready)
        begin
            got = {tri_bus.vertex_a, tri_bus.vertex_b, tri_bus.vertex_c,
                   tri_bus.triangle_half, tri_bus.last};
            if (pending_tris.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected triangle a=%0d b=%0d c=%0d half=%0d last=%0d",
                         $time, got.a, got.b, got.c, got.half, got.last);
            end
            else
            begin
                want = pending_tris.pop_front();
                tris_checked++;
                if (got.half)
                    lower_halves++;
                if (got.a !== want.a || got.b !== want.b || got.c !== want.c ||
                    got.half !== want.half || got.last !== want.last)
                begin
                    errors++;
                    $display("%0t: triangle mismatch exp a=%0d b=%0d c=%0d half=%0d last=%0d",
                             $time, want.a, want.b, want.c, want.half, want.last);
                    $display("%0t:                   got a=%0d b=%0d c=%0d half=%0d last=%0d",
                             $time, got.a, got.b, got.c, got.half, got.last);
                end
            end
        end
    end

    initial
    begin
        int seg;
        int pct;
        tri_bus.ready = 1'b0;
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                tri_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            seg = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
                0:       pct = 0;
                1:       pct = 20;
                2:       pct = 50;
                default: pct = 85;
            endcase
            repeat (seg)
            begin
                tri_bus.ready <= ($urandom_range(0, 99) >= pct);
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int   phase;
        int   target;
        int   limit;
        int   blank_pct;
        bit   wrote;
        tri_t none;
        rst_n                = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = '0;
        cfg_bus.data         = '0;
        sample_bus.valid     = 1'b0;
        sample_bus.elevation = '0;
        grid_cols_reg        = dgt_pkg::GRID_SIZE_RESET;
        grid_rows_reg        = dgt_pkg::GRID_SIZE_RESET;
        nodata_reg           = dgt_pkg::NODATA_RESET;
        none                 = '0;

        // 3x3 grid, reset no-data code
        add_step(STEP_CFG, dgt_pkg::REG_GRID_COLUMNS, 32'd3, -1, none, none);
        add_step(STEP_CFG, dgt_pkg::REG_GRID_ROWS, 32'd3, -1, none, none);
        add_step(STEP_SAMPLE, '0, 32'h7FFF_FFFF, 0, none, none);
        add_step(STEP_SAMPLE, '0, 32'h8000_0000, 0, none, none);
        add_step(STEP_SAMPLE, '0, 32'h0000_0000, 0, none, none);
        add_step(STEP_SAMPLE, '0, 32'hFFFF_FFFF, 0, none, none);
        add_step(STEP_SAMPLE, '0, 32'd5, 2,
                 mk_tri(0, 1, 3, 1'b0, 1'b0), mk_tri(3, 1, 4, 1'b1, 1'b1));
        add_step(STEP_SAMPLE, '0, dgt_pkg::NODATA_RESET, 1, mk_tri(1, 2, 4, 1'b0, 1'b1), none);
        add_step(STEP_SAMPLE, '0, 32'd7, 0, none, none);
        add_step(STEP_SAMPLE, '0, dgt_pkg::NODATA_RESET, 1, mk_tri(3, 4, 6, 1'b0, 1'b1), none);
        add_step(STEP_SAMPLE, '0, 32'd9, 0, none, none);
        // 2x2 grid, smallest no-data code, size word with junk above bit 10
        add_step(STEP_CFG, dgt_pkg::REG_NODATA_VALUE, 32'h8000_0000, -1, none, none);
        add_step(STEP_CFG, dgt_pkg::REG_GRID_COLUMNS, 32'hFFFF_F802, -1, none, none);
        add_step(STEP_CFG, dgt_pkg::REG_GRID_ROWS, 32'd2, -1, none, none);
        add_step(STEP_CFG, REG_UNUSED, 32'd5, -1, none, none);
        add_step(STEP_SAMPLE, '0, 32'h8000_0000, 0, none, none);
        add_step(STEP_SAMPLE, '0, 32'd1, 0, none, none);
        add_step(STEP_SAMPLE, '0, 32'd2, 0, none, none);
        add_step(STEP_SAMPLE, '0, 32'd3, 1, mk_tri(2, 1, 3, 1'b1, 1'b1), none);
        // sizes below the floor saturate to 2, largest no-data code
        add_step(STEP_CFG, dgt_pkg::REG_GRID_COLUMNS, 32'd0, -1, none, none);
        add_step(STEP_CFG, dgt_pkg::REG_GRID_ROWS, 32'd1, -1, none, none);
        add_step(STEP_CFG, dgt_pkg::REG_NODATA_VALUE, 32'h7FFF_FFFF, -1, none, none);
        add_step(STEP_SAMPLE, '0, 32'd1, 0, none, none);
        add_step(STEP_SAMPLE, '0, 32'd2, 0, none, none);
        add_step(STEP_SAMPLE, '0, 32'd3, 0, none, none);
        add_step(STEP_SAMPLE, '0, 32'd4, 2,
                 mk_tri(0, 1, 2, 1'b0, 1'b0), mk_tri(2, 1, 3, 1'b1, 1'b1));
        add_step(STEP_SAMPLE, '0, 32'h7FFF_FFFF, 0, none, none);
        add_step(STEP_SAMPLE, '0, 32'd2, 0, none, none);
        add_step(STEP_SAMPLE, '0, 32'd3, 0, none, none);
        add_step(STEP_SAMPLE, '0, 32'd4, 1, mk_tri(2, 1, 3, 1'b1, 1'b1), none);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_CFG)
                write_reg(plan[i].reg_idx, plan[i].word);
            else
                send_sample(plan[i].word, plan[i].known, plan[i].t0, plan[i].t1);
        end

        // long first row at the widest column setting
        write_reg(dgt_pkg::REG_GRID_COLUMNS, 32'h0000_07FF);
        write_reg(dgt_pkg::REG_GRID_ROWS, 32'h0000_0001);
        write_reg(dgt_pkg::REG_NODATA_VALUE, $urandom());
        hold_pending = 1'b1;
        repeat (WIDE_ROW_SAMPLES) send_sample(pick_elevation(15), -1, none, none);
        // shrink mid-row: current column already past the new row end
        write_reg(dgt_pkg::REG_GRID_COLUMNS, 32'd3);

        phase  = 0;
        target = samples_sent + RANDOM_SAMPLES;
        while (samples_sent < target)
        begin
            wrote = 1'b0;
            limit = (row_cnt == 0) ? MAX_COLUMNS : line_fill;
            if ($urandom_range(0, 1))
            begin
                write_reg(dgt_pkg::REG_GRID_COLUMNS, size_word(pick_size(limit, 12)));
                wrote = 1'b1;
            end
            if ($urandom_range(0, 1))
            begin
                write_reg(dgt_pkg::REG_GRID_ROWS, size_word(pick_size(MAX_ROWS, 8)));
                wrote = 1'b1;
            end
            if (!wrote || $urandom_range(0, 3) == 0)
                write_reg(dgt_pkg::REG_NODATA_VALUE, $urandom());
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_UNUSED, $urandom());
            if (phase % 5 == 2)
                hold_pending = 1'b1;
            blank_pct = ($urandom_range(0, 3) == 0) ? 50 : 12;
            repeat ($urandom_range(20, 90)) send_sample(pick_elevation(blank_pct), -1, none, none);
            phase++;
        end

        sample_bus.valid <= 1'b0;
        while (pending_tris.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d samples over %0d completed grids, %0d triangles checked (%0d lower-right)",
                 samples_sent, grids_done, tris_checked, lower_halves);
        $display("%0d register writes, %0d output hold-offs, %0d mismatches",
                 cfg_writes, holds_done, errors);
        if (errors == 0)
            $display("dem_grid_triangulator_unit regression: pass");
        else
            $display("dem_grid_triangulator_unit regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/dgt_pkg.sv
rtl/core/dgt_cfg_if.sv
rtl/core/dgt_in_if.sv
rtl/core/dgt_out_if.sv
rtl/core/dgt_front.sv
rtl/core/dgt_queue.sv
rtl/core/dgt_back.sv
rtl/core/dem_grid_triangulator_unit.sv
dv/dem_grid_triangulator_unit_test.sv
